@@ src/assert_macros.svh @@
// Assertion macros for the RTL files of the note allocator.
// No dependencies; included by modules that check their own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the rising clock, muted while reset is high.
`define CHECK_PROP(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Concurrent check that also runs during reset.
`define CHECK_ALWAYS(name, clk, prop, msg) \
   name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ src/mnp_pkg.sv @@
// Shared constants, codes and types of the monophonic note allocator.
// No dependencies; imported by mnp_held_map and mono_note_priority.
package mnp_pkg;

   localparam int NOTE_COUNT = 128;
   localparam int NOTE_W     = 7;
   localparam int CHAN_W     = 5;
   localparam int COL_COUNT  = 16;
   localparam int COL_W      = $clog2(COL_COUNT);
   localparam int ROWS       = (NOTE_COUNT + COL_COUNT - 1) / COL_COUNT;
   localparam int ROW_W      = $clog2(ROWS);
   localparam int MOD_STEPS  = 254 / NOTE_COUNT;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 7;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   typedef enum logic [1:0] {
      ACT_NONE    = 2'd0,
      ACT_START   = 2'd1,
      ACT_STOP    = 2'd2,
      ACT_RESTART = 2'd3
   } action_type;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_LISTEN_CHANNEL = 3'd0,
      CSR_TRANSPOSE      = 3'd1,
      CSR_OMNI           = 3'd2,
      CSR_PRIORITY       = 3'd3,
      CSR_GATE_INVERT    = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MODIFY,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                 rd_en;
      logic [ROW_W-1:0]     rd_row;
      logic                 wr_en;
      logic [ROW_W-1:0]     wr_row;
      logic [COL_COUNT-1:0] wr_data;
   } map_req_type;

endpackage

@@ src/mnp_held_map.sv @@
// Held-note map: one row of COL_COUNT note bits per address, registered read.
// Rows never written read as zero through per-row valid bits. Uses mnp_pkg.
module mnp_held_map
   import mnp_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  map_req_type          map_req,
   output logic [COL_COUNT-1:0] rd_data
);

   logic [COL_COUNT-1:0] mem [ROWS];
   logic [ROWS-1:0]      row_valid_ff;
   logic [COL_COUNT-1:0] rd_q_ff;
   logic                 rd_vld_ff;

   always_ff @(posedge clock) begin
      if (map_req.wr_en) begin
         mem[map_req.wr_row] <= map_req.wr_data;
      end
      if (map_req.rd_en) begin
         rd_q_ff <= mem[map_req.rd_row];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_valid_ff <= '0;
         rd_vld_ff    <= 1'b0;
      end else begin
         if (map_req.wr_en) begin
            row_valid_ff[map_req.wr_row] <= 1'b1;
         end
         if (map_req.rd_en) begin
            rd_vld_ff <= row_valid_ff[map_req.rd_row];
         end
      end
   end

   assign rd_data = rd_vld_ff ? rd_q_ff : '0;

endmodule

@@ src/mono_note_priority.sv @@
// Monophonic MIDI note allocator, top level.
// Depends on mnp_pkg, mnp_held_map and assert_macros.svh.
//
// req channel: one note event per beat, tuser = note on (1) / off (0),
// tdata = channel and note. rsp channel: exactly one result beat per event,
// tuser = action code, tdata = sounding note, gate level and sounding flag.
// csr port: plain register writes; the user must make them only while no
// event is in flight, as the block does not enforce it. Held notes live in
// a 16-bit-wide map memory with a registered read. Flow: an event is
// accepted only in the idle state. A note-on, an ignored event or a release
// of a note that is not sounding passes from the update step to the finish
// step. Releasing the sounding note scans the map one row per cycle in
// priority order (8 rows); the scan stops at the first row with a held note.
// The next event is accepted in the cycle after the result is loaded into
// the output register.
// Reset clears the held map (per-row valid bits), the sounding state and
// the registers to their defaults, with no sweep. If the receiver stalls,
// the result waits in the output register; one further event may be
// processed and then holds in its last step until that register frees.
module mono_note_priority
   import mnp_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_tuser,   // [0] op
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [4:0] midi_channel, [11:5] note_number
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [1:0]            rsp_tuser,   // [1:0] action
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [6:0] sounding_note, [7] gate_level,
                                              // [8] sounding
   input  logic                  csr_we,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);
`include "assert_macros.svh"

   localparam logic [7:0] NOTE_COUNT_8 = 8'(NOTE_COUNT);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

   state_type            state_ff, state_in;
   logic [CHAN_W-1:0]    listen_ff;
   logic [NOTE_W-1:0]    transpose_ff;
   logic                 omni_ff, prio_ff, invert_ff;

   logic                 ev_op_ff, ev_op_in;
   logic                 ev_match_ff, ev_match_in;
   logic [NOTE_W-1:0]    ev_note_ff, ev_note_in;
   logic [NOTE_W-1:0]    cur_note_ff, cur_note_in;
   logic                 assigned_ff, assigned_in;
   logic                 gate_ff, gate_in;
   action_type           action_ff, action_in;
   logic [ROW_W-1:0]     scan_idx_ff, scan_idx_in;
   logic                 scan_issue_ff, scan_issue_in;
   logic                 pend_ff, pend_in;
   logic [ROW_W-1:0]     pend_row_ff, pend_row_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_tuser_ff, rsp_tuser_in;
   logic [RSP_DATA_W-1:0] rsp_tdata_ff, rsp_tdata_in;

   map_req_type          map_req;
   logic [COL_COUNT-1:0] rd_data;
   logic [COL_COUNT-1:0] bit_mask;
   logic [7:0]           note_sum;
   logic [NOTE_W-1:0]    in_note;
   logic [CHAN_W-1:0]    in_chan;
   logic                 accept;
   logic                 row_hit;
   logic [COL_W-1:0]     col_lo, col_hi, col_pick;
   logic [NOTE_W-1:0]    pick_note;

   mnp_held_map u_held_map (
      .clock   (clock),
      .reset   (reset),
      .map_req (map_req),
      .rd_data (rd_data)
   );

   // transpose, wrapped into the note range
   always_comb begin
      note_sum = {1'b0, req_tdata[CHAN_W +: NOTE_W]} + {1'b0, transpose_ff};
      for (int i = 0; i < MOD_STEPS; i++) begin
         if (note_sum >= NOTE_COUNT_8) begin
            note_sum = note_sum - NOTE_COUNT_8;
         end
      end
   end

   assign in_note = note_sum[NOTE_W-1:0];
   assign in_chan = req_tdata[CHAN_W-1:0];
   assign accept  = req_tvalid && req_tready;

   // first held column of the row just read, from either end
   always_comb begin
      col_lo = '0;
      col_hi = '0;
      for (int i = COL_COUNT - 1; i >= 0; i--) begin
         if (rd_data[i]) col_lo = COL_W'(i);
      end
      for (int i = 0; i < COL_COUNT; i++) begin
         if (rd_data[i]) col_hi = COL_W'(i);
      end
   end

   assign row_hit   = |rd_data;
   assign col_pick  = prio_ff ? col_hi : col_lo;
   assign pick_note = NOTE_W'({pend_row_ff, col_pick});
   assign bit_mask  = COL_COUNT'(1) << ev_note_ff[COL_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         assigned_ff   <= 1'b0;
         gate_ff       <= 1'b0;
         scan_issue_ff <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         assigned_ff   <= assigned_in;
         gate_ff       <= gate_in;
         scan_issue_ff <= scan_issue_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_op_ff     <= ev_op_in;
      ev_match_ff  <= ev_match_in;
      ev_note_ff   <= ev_note_in;
      cur_note_ff  <= cur_note_in;
      action_ff    <= action_in;
      scan_idx_ff  <= scan_idx_in;
      pend_row_ff  <= pend_row_in;
      rsp_tuser_ff <= rsp_tuser_in;
      rsp_tdata_ff <= rsp_tdata_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         listen_ff    <= CHAN_W'(1);
         transpose_ff <= '0;
         omni_ff      <= 1'b0;
         prio_ff      <= 1'b0;
         invert_ff    <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_LISTEN_CHANNEL: listen_ff    <= csr_wdata[CHAN_W-1:0];
            CSR_TRANSPOSE:      transpose_ff <= csr_wdata[NOTE_W-1:0];
            CSR_OMNI:           omni_ff      <= csr_wdata[0];
            CSR_PRIORITY:       prio_ff      <= csr_wdata[0];
            CSR_GATE_INVERT:    invert_ff    <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      ev_op_in      = ev_op_ff;
      ev_match_in   = ev_match_ff;
      ev_note_in    = ev_note_ff;
      cur_note_in   = cur_note_ff;
      assigned_in   = assigned_ff;
      gate_in       = gate_ff;
      action_in     = action_ff;
      scan_idx_in   = scan_idx_ff;
      scan_issue_in = scan_issue_ff;
      pend_in       = pend_ff;
      pend_row_in   = pend_row_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_tuser_in  = rsp_tuser_ff;
      rsp_tdata_in  = rsp_tdata_ff;
      map_req       = '0;
      req_tready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ev_op_in       = req_tuser;
               ev_match_in    = omni_ff || (in_chan == listen_ff);
               ev_note_in     = in_note;
               map_req.rd_en  = 1'b1;
               map_req.rd_row = ROW_W'(in_note >> COL_W);
               state_in       = ST_MODIFY;
            end
         end
         ST_MODIFY: begin
            action_in = ACT_NONE;
            state_in  = ST_FINISH;
            if (ev_match_ff) begin
               map_req.wr_en  = 1'b1;
               map_req.wr_row = ROW_W'(ev_note_ff >> COL_W);
               if (ev_op_ff) begin
                  map_req.wr_data = rd_data | bit_mask;
                  cur_note_in     = ev_note_ff;
                  assigned_in     = 1'b1;
                  gate_in         = 1'b1;
                  action_in       = ACT_START;
               end else begin
                  map_req.wr_data = rd_data & ~bit_mask;
                  if (assigned_ff && (cur_note_ff == ev_note_ff)) begin
                     gate_in       = 1'b0;
                     action_in     = ACT_STOP;
                     scan_idx_in   = prio_ff ? LAST_ROW : '0;
                     scan_issue_in = 1'b1;
                     pend_in       = 1'b0;
                     state_in      = ST_SCAN;
                  end
               end
            end
         end
         ST_SCAN: begin
            map_req.rd_en  = scan_issue_ff;
            map_req.rd_row = scan_idx_ff;
            pend_in        = scan_issue_ff;
            pend_row_in    = scan_idx_ff;
            if (scan_issue_ff) begin
               if (scan_idx_ff == (prio_ff ? '0 : LAST_ROW)) begin
                  scan_issue_in = 1'b0;
               end else begin
                  scan_idx_in = prio_ff ? scan_idx_ff - 1'b1 : scan_idx_ff + 1'b1;
               end
            end
            if (pend_ff) begin
               if (row_hit) begin
                  cur_note_in   = pick_note;
                  gate_in       = 1'b1;
                  action_in     = ACT_RESTART;
                  pend_in       = 1'b0;
                  scan_issue_in = 1'b0;
                  state_in      = ST_FINISH;
               end else if (!scan_issue_ff) begin
                  pend_in  = 1'b0;
                  state_in = ST_FINISH;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_tuser_in = action_ff;
               rsp_tdata_in = RSP_DATA_W'({gate_ff, gate_ff ^ invert_ff,
                                           assigned_ff ? cur_note_ff : NOTE_W'(0)});
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tdata  = rsp_tdata_ff;

   `CHECK_PROP(a_accept_to_modify, clock, reset, accept |=> (state_ff == ST_MODIFY),
      "accepted event did not reach the update step")
   `CHECK_PROP(a_write_then_move, clock, reset,
      map_req.wr_en |=> (state_ff == ST_SCAN || state_ff == ST_FINISH),
      "map write outside the update step")
   `CHECK_PROP(a_start_sounds, clock, reset,
      (rsp_valid_ff && (rsp_tuser_ff == ACT_START || rsp_tuser_ff == ACT_RESTART))
         |-> rsp_tdata_ff[NOTE_W+1],
      "start or restart reported without a sounding note")
   `CHECK_ALWAYS(a_scan_no_write, clock, (state_ff == ST_SCAN) |-> !map_req.wr_en,
      "map written during the priority scan")

endmodule

@@ tb/mono_note_priority_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the mono_note_priority note allocator.
// Drives note events and register writes, predicts each result beat in place.
// Depends on mnp_pkg and the RTL of mono_note_priority.
module mono_note_priority_test;
   import mnp_pkg::*;

   typedef struct packed {
      logic              op;
      logic [CHAN_W-1:0] chan;
      logic [NOTE_W-1:0] note;
   } note_event;

   typedef struct packed {
      action_type        action;
      logic [NOTE_W-1:0] note;
      logic              gate_level;
      logic              sounding;
   } alloc_result;

   localparam logic [CSR_ADDR_W-1:0] CSR_SPARE_INDEX = 3'd6;
   localparam logic [7:0]            NO_NOTE         = 8'd255;
   localparam int                    MAX_REPORTS     = 10;
   localparam int                    HOLD_CYCLES     = 300;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic                  req_tuser  = 1'b0;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // [4:0] midi_channel, [11:5] note_number
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [1:0]            rsp_tuser;         // [1:0] action
   logic [RSP_DATA_W-1:0] rsp_tdata;         // [6:0] sounding_note, [7] gate_level, [8] sounding
   logic                  csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   note_event   event_queue[$];
   alloc_result due_results[$];
   int          mismatch_count = 0;
   bit          idling_on      = 1'b0;
   logic        long_hold_req  = 1'b0;
   int          send_gap       = 0;
   int          stall_left     = 0;
   int          hold_left      = 0;

   // stimulus-side view of the registers
   int          cfg_listen = 1;
   bit          cfg_omni   = 1'b0;

   // predictor state
   logic [CHAN_W-1:0] listen_q;
   logic [NOTE_W-1:0] shift_q;
   logic              omni_q;
   logic              highest_q;
   logic              invert_q;
   logic              held[NOTE_COUNT];
   logic [7:0]        cur_note;
   logic              gate_on;

   mono_note_priority i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tuser  (rsp_tuser),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #1 clock = ~clock;

   function automatic alloc_result allocate(note_event ev);
      alloc_result       r;
      logic [NOTE_W-1:0] n;
      int                idx;
      int                pick;
      r.action = ACT_NONE;
      if (omni_q || ev.chan == listen_q) begin
         n = ev.note + shift_q;
         if (ev.op) begin
            held[n]  = 1'b1;
            cur_note = {1'b0, n};
            gate_on  = 1'b1;
            r.action = ACT_START;
         end else if (cur_note == {1'b0, n}) begin
            held[n]  = 1'b0;
            gate_on  = 1'b0;
            r.action = ACT_STOP;
            pick     = -1;
            for (int i = 0; i < NOTE_COUNT; i++) begin
               idx = highest_q ? NOTE_COUNT - 1 - i : i;
               if (pick < 0 && held[idx]) pick = idx;
            end
            if (pick >= 0) begin
               cur_note = 8'(pick);
               gate_on  = 1'b1;
               r.action = ACT_RESTART;
            end
         end else begin
            held[n] = 1'b0;
         end
      end
      r.note       = (cur_note == NO_NOTE) ? '0 : cur_note[NOTE_W-1:0];
      r.gate_level = gate_on ^ invert_q;
      r.sounding   = gate_on;
      return r;
   endfunction

   // predictor: follows register writes and accepted event beats
   always @(posedge clock) begin
      if (reset) begin
         listen_q  <= 5'd1;
         shift_q   <= '0;
         omni_q    <= 1'b0;
         highest_q <= 1'b0;
         invert_q  <= 1'b0;
         cur_note  <= NO_NOTE;
         gate_on   <= 1'b0;
         for (int i = 0; i < NOTE_COUNT; i++) held[i] <= 1'b0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_LISTEN_CHANNEL: listen_q  <= csr_wdata[CHAN_W-1:0];
               CSR_TRANSPOSE:      shift_q   <= csr_wdata[NOTE_W-1:0];
               CSR_OMNI:           omni_q    <= csr_wdata[0];
               CSR_PRIORITY:       highest_q <= csr_wdata[0];
               CSR_GATE_INVERT:    invert_q  <= csr_wdata[0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready)
            due_results.push_back(allocate({req_tuser, req_tdata[4:0], req_tdata[11:5]}));
      end
   end

   // driver
   always @(posedge clock) begin
      note_event ev;
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap   <= 0;
      end else if (req_tvalid && !req_tready) begin
      end else if (send_gap != 0) begin
         req_tvalid <= 1'b0;
         send_gap   <= send_gap - 1;
      end else if (event_queue.size() != 0) begin
         if (idling_on && $urandom_range(0, 5) == 0) begin
            req_tvalid <= 1'b0;
            send_gap   <= $urandom_range(0, 18);
         end else begin
            ev = event_queue.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= ev.op;
            req_tdata  <= {4'b0, ev.note, ev.chan};
         end
      end else begin
         req_tvalid <= 1'b0;
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
         hold_left  <= 0;
      end else if (long_hold_req) begin
         hold_left  <= HOLD_CYCLES;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 18);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor
   always @(posedge clock) begin
      alloc_result want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (due_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: unexpected result beat action=%0d tdata=%h",
                        $realtime, rsp_tuser, rsp_tdata);
         end else begin
            want = due_results.pop_front();
            if (rsp_tuser !== want.action || rsp_tdata[6:0] !== want.note ||
                rsp_tdata[7] !== want.gate_level || rsp_tdata[8] !== want.sounding ||
                rsp_tdata[RSP_DATA_W-1:9] !== '0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display("%0t: expected action=%0d note=%0d gate=%0b sounding=%0b, got action=%0d note=%0d gate=%0b sounding=%0b tdata=%h",
                           $realtime, want.action, want.note, want.gate_level, want.sounding,
                           rsp_tuser, rsp_tdata[6:0], rsp_tdata[7], rsp_tdata[8], rsp_tdata);
            end
         end
      end
   end

   task automatic push_event(bit op, int chan, int note);
      event_queue.push_back({op, 5'(chan), 7'(note)});
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (event_queue.size() != 0 || req_tvalid || due_results.size() != 0);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-1:0] index, int value);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= 7'(value);
   endtask

   task automatic set_config(int listen, int shift, bit omni, bit highest, bit invert);
      wait_drained();
      csr_write(CSR_LISTEN_CHANNEL, listen);
      csr_write(CSR_TRANSPOSE, shift);
      csr_write(CSR_OMNI, omni);
      csr_write(CSR_PRIORITY, highest);
      csr_write(CSR_GATE_INVERT, invert);
      csr_write(CSR_SPARE_INDEX, $urandom_range(0, 127));
      @(posedge clock);
      csr_we     <= 1'b0;
      cfg_listen  = listen & 31;
      cfg_omni    = omni;
   endtask

   // mostly events on the listened channel over a small note pool, some noise
   task automatic run_random(int count, int pool_n);
      int pool[8];
      int chan;
      for (int k = 0; k < 8; k++) pool[k] = $urandom_range(0, 127);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 99) < 15) begin
            push_event($urandom_range(0, 1), $urandom_range(0, 31), $urandom_range(0, 127));
         end else begin
            chan = cfg_omni ? $urandom_range(0, 31) : cfg_listen;
            push_event($urandom_range(0, 99) < 55, chan, pool[$urandom_range(0, pool_n - 1)]);
         end
      end
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      idling_on = 1'b1;

      // defaults: channel 1, no transpose, lowest priority
      push_event(0, 1, 5);      // release with nothing assigned
      push_event(1, 2, 60);     // other channel
      push_event(1, 1, 0);
      push_event(1, 1, 127);
      push_event(1, 1, 64);
      push_event(0, 1, 64);     // restart lowest
      push_event(0, 1, 0);
      push_event(0, 1, 127);    // stop, note stays assigned
      push_event(0, 1, 127);    // stop again while silent
      push_event(0, 1, 10);     // not held
      push_event(1, 0, 1);
      push_event(1, 31, 2);
      push_event(1, 17, 3);
      push_event(1, 1, 30);
      push_event(1, 1, 40);
      push_event(0, 1, 30);     // held but not sounding
      push_event(0, 1, 40);

      set_config(16, 127, 0, 1, 1);
      push_event(1, 16, 0);     // transposed to 127
      push_event(1, 16, 1);
      push_event(1, 16, 5);
      push_event(0, 16, 6);
      push_event(0, 16, 5);     // restart highest
      push_event(1, 1, 9);
      push_event(0, 16, 0);
      push_event(0, 16, 1);

      set_config(0, 0, 0, 0, 0);
      run_random(60, 4);
      set_config(127, 64, 0, 1, 0);   // channel register keeps 5 bits
      run_random(60, 6);
      repeat (5) begin
         set_config($urandom_range(1, 16), $urandom_range(0, 127), $urandom_range(0, 1),
                    $urandom_range(0, 1), $urandom_range(0, 1));
         run_random(60, $urandom_range(2, 8));
      end

      // receiver holds off while events keep coming
      wait_drained();
      @(posedge clock);
      long_hold_req <= 1'b1;
      @(posedge clock);
      long_hold_req <= 1'b0;
      run_random(20, 4);

      set_config(1, 0, 1, 0, 0);
      idling_on = 1'b0;
      run_random(60, 5);

      wait_drained();
      repeat (16) @(posedge clock);
      if (mismatch_count == 0 && due_results.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule
